### design/fsif_pkg.sv
// Package for the decimal integer format engine.
// Holds the command type between front and back, the back-end state type and character codes.
// No dependencies.
package fsif_pkg;

	localparam int FMT_CHAR_W   = 8;
	localparam int INT_ARG_W    = 32;
	localparam int CHAR_COUNT_W = 16;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// A 32-bit magnitude has at most ten decimal digits.
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS + 1);

	localparam logic [FMT_CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [FMT_CHAR_W-1:0] CHAR_PCT   = 8'h25;
	localparam logic [FMT_CHAR_W-1:0] CHAR_D     = 8'h64;
	localparam logic [FMT_CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [FMT_CHAR_W-1:0] CHAR_ZERO  = 8'h30;

	// Division by ten: q = (x * DIV10_RECIP) >> DIV10_SHIFT is exact for all 32-bit x.
	localparam logic [INT_ARG_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_CHAR,
		CMD_DEC
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [FMT_CHAR_W-1:0]  ch;
		logic [INT_ARG_W-1:0]   arg;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_EMIT
	} back_state_t;

endpackage

### design/format_string_int_formatter_unit.sv
// Top level of the decimal integer format engine (printf-style %d subset).
// Instantiates fsif_front, fsif_cmd_fifo and fsif_back; depends on fsif_pkg.
//
//   Channel   Handshake          Beat contents
//   input     push / full        fmt_char, int_arg
//   result    empty / pop        out_char, char_count, last
//
// A plain byte or %% yields one result beat; a %d runs the divide-by-ten loop, which
// produces one digit per cycle, and then emits an optional minus sign and the digits
// at one result beat per cycle while the output register is free (empty or popped).
// The command queue lets the front accept bytes while the back end is still converting.
// Reset clears the pending percent flag, the count, the queue and the output valid flag.
// A held result (pop low) stalls the back end's result beats; a full queue raises full.
module format_string_int_formatter_unit #(
	parameter int CountBits  = fsif_pkg::COUNT_BITS_DEF,
	parameter int QueueDepth = fsif_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [fsif_pkg::FMT_CHAR_W-1:0]        fmt_char,
	input  logic signed [fsif_pkg::INT_ARG_W-1:0]  int_arg,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [fsif_pkg::FMT_CHAR_W-1:0]        out_char,
	output logic [fsif_pkg::CHAR_COUNT_W-1:0]      char_count,
	output logic                                   last
);

	fsif_pkg::cmd_t cmd_w;
	fsif_pkg::cmd_t cmd_r;
	logic           cmd_push;
	logic           cmd_full;
	logic           cmd_pop;
	logic           cmd_empty;

	fsif_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.fmt_char (fmt_char),
		.int_arg  (int_arg),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_w)
	);

	fsif_cmd_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_w),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_r),
		.empty  (cmd_empty)
	);

	fsif_back #(
		.CountBits (CountBits)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_r),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.char_count (char_count),
		.last       (last)
	);

endmodule

### design/fsif_front.sv
// Front end: accepts format bytes, tracks a pending percent sign and turns the bytes into
// commands (not an opening % or an unknown conversion). Depends on fsif_pkg.
module fsif_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [fsif_pkg::FMT_CHAR_W-1:0]     fmt_char,
	input  logic signed [fsif_pkg::INT_ARG_W-1:0] int_arg,
	input  logic                                cmd_full,
	output logic                                cmd_push,
	output fsif_pkg::cmd_t                      cmd
);

	logic pending_q;
	logic accept;
	logic enq;
	logic pending_d;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	always_comb begin
		enq       = 1'b0;
		pending_d = pending_q;
		cmd.kind  = fsif_pkg::CMD_CHAR;
		cmd.ch    = fmt_char;
		cmd.arg   = int_arg;
		if (fmt_char == fsif_pkg::CHAR_NUL) begin
			// End of format: the back end clears the count in order with the other beats.
			enq       = 1'b1;
			pending_d = 1'b0;
			cmd.kind  = fsif_pkg::CMD_CLEAR;
		end else if (pending_q) begin
			pending_d = 1'b0;
			if (fmt_char == fsif_pkg::CHAR_PCT) begin
				enq = 1'b1;
			end else if (fmt_char == fsif_pkg::CHAR_D) begin
				enq      = 1'b1;
				cmd.kind = fsif_pkg::CMD_DEC;
			end
		end else if (fmt_char == fsif_pkg::CHAR_PCT) begin
			pending_d = 1'b1;
		end else begin
			enq = 1'b1;
		end
	end

	assign cmd_push = accept && enq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= pending_d;
		end
	end

endmodule

### design/fsif_cmd_fifo.sv
// Command queue between front and back end.
// Register-based circular buffer. Depends on fsif_pkg.
module fsif_cmd_fifo #(
	parameter int Depth = fsif_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsif_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output fsif_pkg::cmd_t rdata,
	output logic           empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	fsif_pkg::cmd_t  mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (fill_q == CntW'(Depth));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### design/fsif_back.sv
// Back end: executes commands, converts %d arguments to decimal one digit per cycle
// and holds each result beat in an output register. Depends on fsif_pkg.
module fsif_back #(
	parameter int CountBits = fsif_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_empty,
	input  fsif_pkg::cmd_t                       cmd,
	output logic                                 cmd_pop,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [fsif_pkg::FMT_CHAR_W-1:0]      out_char,
	output logic [fsif_pkg::CHAR_COUNT_W-1:0]    char_count,
	output logic                                 last
);

	localparam int AW   = fsif_pkg::INT_ARG_W;
	localparam int IW   = fsif_pkg::DIGIT_IDX_W;
	localparam int ExtW = (CountBits > fsif_pkg::CHAR_COUNT_W) ? CountBits
	                                                           : fsif_pkg::CHAR_COUNT_W;

	fsif_pkg::back_state_t state_q, state_d;

	logic [CountBits-1:0]          count_q;
	logic [CountBits-1:0]          count_inc;
	logic [ExtW-1:0]               count_ext;
	logic                          neg_q;
	logic [AW-1:0]                 mag_q;
	logic [IW-1:0]                 nd_q;
	logic [3:0]                    digit_q [fsif_pkg::MAX_DIGITS];

	logic                          out_valid_q;
	logic [fsif_pkg::FMT_CHAR_W-1:0] out_char_q;
	logic [fsif_pkg::CHAR_COUNT_W-1:0] out_count_q;
	logic                          out_last_q;

	logic                          slot_free;
	logic                          emit;
	logic                          emit_last;
	logic [fsif_pkg::FMT_CHAR_W-1:0] emit_char;

	logic [2*AW-1:0]               prod;
	logic [AW-1:0]                 quot;
	logic [AW-1:0]                 rem_full;
	logic [IW-1:0]                 rd_idx;

	assign slot_free = !out_valid_q || pop;

	// Reciprocal multiply for the divide by ten, then the remainder by shift-and-add.
	assign prod     = (2*AW)'(mag_q) * (2*AW)'(fsif_pkg::DIV10_RECIP);
	assign quot     = AW'(prod[2*AW-1:fsif_pkg::DIV10_SHIFT]);
	assign rem_full = mag_q - ((quot << 3) + (quot << 1));
	assign rd_idx   = nd_q - 1'b1;

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign count_ext = ExtW'(count_inc);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsif_pkg::BK_IDLE: begin
				if (!cmd_empty && cmd.kind == fsif_pkg::CMD_DEC) begin
					state_d = fsif_pkg::BK_DIV;
				end
			end
			fsif_pkg::BK_DIV: begin
				if (quot == '0) begin
					state_d = neg_q ? fsif_pkg::BK_SIGN : fsif_pkg::BK_EMIT;
				end
			end
			fsif_pkg::BK_SIGN: begin
				if (slot_free) begin
					state_d = fsif_pkg::BK_EMIT;
				end
			end
			fsif_pkg::BK_EMIT: begin
				if (slot_free && nd_q == IW'(1)) begin
					state_d = fsif_pkg::BK_IDLE;
				end
			end
			default: state_d = fsif_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_char = cmd.ch;
		case (state_q)
			fsif_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						fsif_pkg::CMD_CHAR: begin
							cmd_pop   = slot_free;
							emit      = slot_free;
							emit_last = 1'b1;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			fsif_pkg::BK_SIGN: begin
				emit      = slot_free;
				emit_char = fsif_pkg::CHAR_MINUS;
			end
			fsif_pkg::BK_EMIT: begin
				emit      = slot_free;
				emit_last = (nd_q == IW'(1));
				emit_char = fsif_pkg::CHAR_ZERO | {4'd0, digit_q[rd_idx]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsif_pkg::BK_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop && cmd.kind == fsif_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else if (emit) begin
				count_q <= count_inc;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q  <= emit_char;
			out_count_q <= count_ext[fsif_pkg::CHAR_COUNT_W-1:0];
			out_last_q  <= emit_last;
		end
		case (state_q)
			fsif_pkg::BK_IDLE: begin
				neg_q <= cmd.arg[AW-1];
				mag_q <= cmd.arg[AW-1] ? (AW'(0) - cmd.arg) : cmd.arg;
				nd_q  <= '0;
			end
			fsif_pkg::BK_DIV: begin
				digit_q[nd_q] <= rem_full[3:0];
				mag_q         <= quot;
				nd_q          <= nd_q + 1'b1;
			end
			fsif_pkg::BK_EMIT: begin
				if (slot_free) begin
					nd_q <= rd_idx;
				end
			end
			default: ;
		endcase
	end

	assign empty      = !out_valid_q;
	assign out_char   = out_char_q;
	assign char_count = out_count_q;
	assign last       = out_last_q;

endmodule
